>>> rtl/core/mtf_pkg.sv
// Shared constants, types and controller state codes for the move-to-front codec.
`timescale 1ns / 1ps

package mtf_pkg;

	// Symbol and position width.
	localparam int DATA_W = 8;

	// Default list depth.
	localparam int MTF_DEPTH = 256;

	// Width of the return word reduced from the cell row.
	localparam int RET_W = 1 + 2 * DATA_W;

	// Cells per first-level group of the return tree.
	localparam int TREE_GRP = 16;

	// Controller states, one-hot.
	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_WALK = 3'b010,
		ST_HOLD = 3'b100
	} mtf_state_t;

	// Report of the cell where the walk stopped; all zero from other cells.
	typedef struct packed {
		logic              found;
		logic [DATA_W-1:0] pos;
		logic [DATA_W-1:0] sym;
	} mtf_ret_t;

endpackage

>>> rtl/core/mtf_cell.sv
// One list entry of the move-to-front row, with the walking token and carry stage.
`timescale 1ns / 1ps

module mtf_cell
	import mtf_pkg::*;
#(
	parameter int IDX  = 0,
	parameter bit LAST = 1'b0
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              tok_in,     // token arrives from the previous cell
	input  logic [DATA_W-1:0] carry_in,   // old entry of the previous cell
	input  logic              self_carry, // take own entry as the carry
	input  logic              decode,
	input  logic [DATA_W-1:0] sym,
	input  logic [DATA_W-1:0] pos,
	input  logic              front_we,
	input  logic [DATA_W-1:0] front_sym,
	output logic              tok_out,
	output logic [DATA_W-1:0] carry_out,
	output mtf_ret_t          ret
);

	localparam logic [DATA_W-1:0] IDX_V = DATA_W'(IDX);

	logic [DATA_W-1:0] val_q;
	logic [DATA_W-1:0] carry_q;
	logic              tok_q;
	logic [DATA_W-1:0] carry_sel;
	logic              hit;
	logic              stop;

	// Decide whether the token ends here
	assign carry_sel = self_carry ? val_q : carry_in;
	assign hit       = decode ? (pos == IDX_V) : (val_q == sym);
	assign stop      = tok_in & (hit | LAST);

	// Take the carry, pass the token on unless it stops here
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			val_q <= IDX_V;
			tok_q <= 1'b0;
		end else begin
			tok_q <= tok_in & ~stop;
			if (tok_in) begin
				val_q <= carry_sel;
			end else if (front_we) begin
				val_q <= front_sym;
			end
		end
	end

	// Hand the displaced entry to the next cell
	always_ff @(posedge clk) begin
		if (tok_in) begin
			carry_q <= val_q;
		end
	end

	assign tok_out   = tok_q;
	assign carry_out = carry_q;

	// Report position and old entry of the stopping cell
	assign ret.found = stop;
	assign ret.pos   = stop ? IDX_V : '0;
	assign ret.sym   = stop ? val_q : '0;

endmodule

>>> rtl/core/mtf_or_tree.sv
// Registered OR reduction of the cell reports down to one return word.
`timescale 1ns / 1ps

module mtf_or_tree
	import mtf_pkg::*;
#(
	parameter int N = MTF_DEPTH
) (
	input  logic     clk,
	input  logic     arst_n,
	input  mtf_ret_t d [N],
	output mtf_ret_t q
);

	localparam int NG = (N + TREE_GRP - 1) / TREE_GRP;

	logic [RET_W-1:0] pad   [NG*TREE_GRP];
	logic [RET_W-1:0] grp_d [NG];
	logic [RET_W-1:0] grp_q [NG];
	logic [RET_W-1:0] acc;

	// Pad the row to whole groups
	for (genvar j = 0; j < NG * TREE_GRP; j++) begin : g_pad
		if (j < N) begin : g_real
			assign pad[j] = d[j];
		end else begin : g_zero
			assign pad[j] = '0;
		end
	end

	// Reduce each group
	for (genvar g = 0; g < NG; g++) begin : g_grp
		always_comb begin
			grp_d[g] = '0;
			for (int i = 0; i < TREE_GRP; i++) begin
				grp_d[g] = grp_d[g] | pad[g*TREE_GRP + i];
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				grp_q[g] <= '0;
			end else begin
				grp_q[g] <= grp_d[g];
			end
		end
	end

	// Reduce the group registers
	always_comb begin
		acc = '0;
		for (int g = 0; g < NG; g++) begin
			acc = acc | grp_q[g];
		end
	end

	assign q = mtf_ret_t'(acc);

endmodule

>>> rtl/core/move_to_front_codec.sv
// Top level of the byte-wise move-to-front encoder and decoder.
`timescale 1ns / 1ps

// Move-to-front codec over a list of LIST_DEPTH byte symbols, entry i holding
// i after reset. With decode_mode low each input word is a symbol and the
// output word is its list position; with decode_mode high each input word is
// a position (saturated to LIST_DEPTH-1) and the output word is the symbol
// there. Either way that symbol then moves to the front. One word is worked
// at a time: a token walks the row of list cells one cell per cycle, the
// stopping cell's report is registered in the OR tree, and the next word is
// accepted only once the result has been loaded into the output register.
// The output register lets the next word be accepted while a result waits.
// Write decode_mode through cfg_we/cfg_wdata only while no word is in flight.

module move_to_front_codec
	import mtf_pkg::*;
#(
	parameter int LIST_DEPTH = MTF_DEPTH
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic              cfg_wdata,  // decode_mode
	input  logic              s_tvalid,
	output logic              s_tready,
	input  logic [DATA_W-1:0] s_tdata,    // [7:0] data_in
	output logic              m_tvalid,
	input  logic              m_tready,
	output logic [DATA_W-1:0] m_tdata     // [7:0] data_out
);

	localparam logic [DATA_W-1:0] LAST_POS = DATA_W'(LIST_DEPTH - 1);

	mtf_state_t        state_q;
	logic              mode_q;
	logic [DATA_W-1:0] sym_q;
	logic [DATA_W-1:0] pos_q;
	logic              start_q;
	logic [DATA_W-1:0] res_q;
	logic [DATA_W-1:0] m_tdata_q;
	logic              m_tvalid_q;

	logic              accept;
	logic              out_free;
	logic              found;
	logic              front_we;
	logic              load_out;
	logic [DATA_W-1:0] front_sym;
	logic [DATA_W-1:0] result;
	logic [DATA_W-1:0] in_pos;

	logic              tok_c   [LIST_DEPTH+1];
	logic [DATA_W-1:0] carry_c [LIST_DEPTH+1];
	mtf_ret_t          ret_c   [LIST_DEPTH];
	mtf_ret_t          tree_q;
	logic [LIST_DEPTH-1:0] tok_vec;

	// Handshake and result selection
	assign s_tready  = (state_q == ST_IDLE);
	assign accept    = s_tvalid & s_tready;
	assign out_free  = ~m_tvalid_q | m_tready;
	assign found     = tree_q.found;
	assign front_we  = (state_q == ST_WALK) & found;
	assign front_sym = mode_q ? tree_q.sym : sym_q;
	assign result    = mode_q ? tree_q.sym : tree_q.pos;
	assign in_pos    = (s_tdata > LAST_POS) ? LAST_POS : s_tdata;
	assign load_out  = (((state_q == ST_WALK) & found) | (state_q == ST_HOLD)) & out_free;

	// Feed the head of the row
	assign tok_c[0]   = start_q;
	assign carry_c[0] = sym_q;

	// Row of list cells
	for (genvar k = 0; k < LIST_DEPTH; k++) begin : g_cell
		if (k == LIST_DEPTH - 1) begin : g_last
			mtf_cell #(.IDX(k), .LAST(1'b1)) u_cell (
				.clk        (clk),
				.arst_n     (arst_n),
				.tok_in     (tok_c[k]),
				.carry_in   (carry_c[k]),
				.self_carry (1'b0),
				.decode     (mode_q),
				.sym        (sym_q),
				.pos        (pos_q),
				.front_we   (1'b0),
				.front_sym  (front_sym),
				.tok_out    (tok_c[k+1]),
				.carry_out  (carry_c[k+1]),
				.ret        (ret_c[k])
			);
		end else begin : g_mid
			mtf_cell #(.IDX(k), .LAST(1'b0)) u_cell (
				.clk        (clk),
				.arst_n     (arst_n),
				.tok_in     (tok_c[k]),
				.carry_in   (carry_c[k]),
				.self_carry ((k == 0) ? mode_q : 1'b0),
				.decode     (mode_q),
				.sym        (sym_q),
				.pos        (pos_q),
				.front_we   ((k == 0) ? front_we : 1'b0),
				.front_sym  (front_sym),
				.tok_out    (tok_c[k+1]),
				.carry_out  (carry_c[k+1]),
				.ret        (ret_c[k])
			);
		end
		assign tok_vec[k] = tok_c[k];
	end

	// Collect the stopping cell's report
	mtf_or_tree #(.N(LIST_DEPTH)) u_tree (
		.clk    (clk),
		.arst_n (arst_n),
		.d      (ret_c),
		.q      (tree_q)
	);

	// Mode register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= 1'b0;
		end else if (cfg_we) begin
			mode_q <= cfg_wdata;
		end
	end

	// Latch the accepted word, and a result that must wait for the output register
	always_ff @(posedge clk) begin
		if (accept) begin
			sym_q <= s_tdata;
			pos_q <= in_pos;
		end
		if ((state_q == ST_WALK) && found && !out_free) begin
			res_q <= result;
		end
	end

	// Sequence the walk and the output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			start_q    <= 1'b0;
			m_tvalid_q <= 1'b0;
			m_tdata_q  <= '0;
		end else begin
			start_q <= accept;
			if (load_out) begin
				m_tvalid_q <= 1'b1;
				m_tdata_q  <= (state_q == ST_HOLD) ? res_q : result;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						state_q <= ST_WALK;
					end
				end
				ST_WALK: begin
					if (found) begin
						state_q <= out_free ? ST_IDLE : ST_HOLD;
					end
				end
				ST_HOLD: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

`ifndef SYNTH
	// At most one token in the row
	a_one_token: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(tok_vec))
		else $error("more than one token in the cell row");

	// Reports arrive only while walking
	a_found_walk: assert property (@(posedge clk) disable iff (!arst_n)
		found |-> (state_q == ST_WALK))
		else $error("cell report outside of a walk");

	// An accepted word launches the token
	a_launch: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (start_q && (state_q == ST_WALK)))
		else $error("accepted word did not launch a walk");

	// A held result means the output register is occupied
	a_hold_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_HOLD) |-> m_tvalid_q)
		else $error("result held while output register is empty");
`endif

endmodule

>>> tb/sv/tb.sv
// Self-checking testbench for the byte-wise move-to-front codec.
`timescale 1ns / 1ps

module tb;
	import mtf_pkg::*;

	localparam int LIST_DEPTH = MTF_DEPTH;

	// decode_mode register values
	localparam logic MODE_ENC = 1'b0;
	localparam logic MODE_DEC = 1'b1;

	localparam int N_DIR = 16;
	localparam int N_PHASE = 6;
	localparam int PHASE_WORDS = 200;
	localparam int TAIL_WORDS = 150;
	localparam int HOLD_AT = 350;
	localparam int HOLD_CYCLES = 600;

	// One directed row: a mode write, or a word with an optional typed-in result.
	typedef struct {
		bit         is_cfg;
		logic [7:0] val;
		bit         typed;
		logic [7:0] want;
	} dir_row_t;

	logic              clk;
	logic              arst_n;
	logic              cfg_we;
	logic              cfg_wdata;
	logic              s_tvalid;
	logic              s_tready;
	logic [DATA_W-1:0] s_tdata;
	logic              m_tvalid;
	logic              m_tready;
	logic [DATA_W-1:0] m_tdata;

	logic [7:0] sym_list [LIST_DEPTH];
	logic       decode_on;
	logic [7:0] pending_out [$];
	int         fails;
	bit         quiet_tail;
	bit         hold_output;

	// After reset: 255 moves up from the back, then 0 and 254 take their turns.
	dir_row_t dir_rows [N_DIR] = '{
		'{1'b0, 8'd0,   1'b1, 8'd0},
		'{1'b0, 8'd255, 1'b1, 8'd255},
		'{1'b0, 8'd255, 1'b1, 8'd0},
		'{1'b0, 8'd0,   1'b1, 8'd1},
		'{1'b0, 8'd254, 1'b1, 8'd255},
		'{1'b0, 8'd128, 1'b0, 8'd0},
		'{1'b0, 8'd1,   1'b0, 8'd0},
		'{1'b1, {7'd0, MODE_DEC}, 1'b0, 8'd0},
		'{1'b0, 8'd0,   1'b0, 8'd0},
		'{1'b0, 8'd255, 1'b0, 8'd0},
		'{1'b0, 8'd1,   1'b0, 8'd0},
		'{1'b0, 8'd128, 1'b0, 8'd0},
		'{1'b0, 8'd0,   1'b0, 8'd0},
		'{1'b1, {7'd0, MODE_ENC}, 1'b0, 8'd0},
		'{1'b0, 8'd170, 1'b0, 8'd0},
		'{1'b0, 8'd85,  1'b0, 8'd0}
	};

	move_to_front_codec dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),     // [7:0] data_in
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata)      // [7:0] data_out
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// Translate one word through the list copy and move its symbol to the front.
	function automatic logic [7:0] mtf_translate(input logic [7:0] din);
		int         pos;
		int         k;
		logic [7:0] sym;
		if (decode_on == MODE_DEC) begin
			pos = din;
			if (pos >= LIST_DEPTH)
				pos = LIST_DEPTH - 1;
			sym = sym_list[pos];
		end else begin
			sym = din;
			pos = LIST_DEPTH - 1;
			for (k = LIST_DEPTH - 1; k >= 0; k--)
				if (sym_list[k] == sym)
					pos = k;
		end
		for (k = pos; k > 0; k--)
			sym_list[k] = sym_list[k - 1];
		sym_list[0] = sym;
		return (decode_on == MODE_DEC) ? sym : pos[7:0];
	endfunction

	// Offer one word, record its result once taken, then maybe idle.
	task automatic offer_word(input logic [7:0] din, input bit typed, input logic [7:0] want);
		logic [7:0] predicted;
		s_tvalid <= 1'b1;
		s_tdata  <= din;
		do @(posedge clk); while (!s_tready);
		predicted = mtf_translate(din);
		pending_out.push_back(typed ? want : predicted);
		if (!quiet_tail && $urandom_range(0, 5) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 9)) @(posedge clk);
		end
	endtask

	// Write decode_mode once every word in flight has come out.
	task automatic write_mode(input logic mode);
		s_tvalid <= 1'b0;
		while (pending_out.size() != 0)
			@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_wdata <= mode;
		@(posedge clk);
		cfg_we    <= 1'b0;
		decode_on = mode;
	endtask

	// Pick a word: mostly recently used symbols or near positions, sometimes anything.
	function automatic logic [7:0] pick_word();
		if ($urandom_range(0, 9) < 3)
			return 8'($urandom_range(0, 255));
		if (decode_on == MODE_DEC)
			return 8'($urandom_range(0, 15));
		return sym_list[$urandom_range(0, 15)];
	endfunction

	// Stimulus: reset, directed rows, then random phases in alternating modes.
	initial begin
		int n;
		int ph;
		int i;
		arst_n      <= 1'b0;
		cfg_we      <= 1'b0;
		cfg_wdata   <= 1'b0;
		s_tvalid    <= 1'b0;
		s_tdata     <= '0;
		fails       = 0;
		quiet_tail  = 1'b0;
		hold_output = 1'b0;
		decode_on   = MODE_ENC;
		for (i = 0; i < LIST_DEPTH; i++)
			sym_list[i] = 8'(i);
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (i = 0; i < N_DIR; i++) begin
			if (dir_rows[i].is_cfg)
				write_mode(dir_rows[i].val[0]);
			else
				offer_word(dir_rows[i].val, dir_rows[i].typed, dir_rows[i].want);
		end

		n = 0;
		for (ph = 0; ph < N_PHASE; ph++) begin
			write_mode((ph % 2 == 0) ? MODE_DEC : MODE_ENC);
			for (i = 0; i < PHASE_WORDS; i++) begin
				if (n == HOLD_AT)
					hold_output = 1'b1;
				if (n == N_PHASE * PHASE_WORDS - TAIL_WORDS)
					quiet_tail = 1'b1;
				offer_word(pick_word(), 1'b0, 8'd0);
				n++;
			end
		end

		// Drain and let the block settle before the verdict.
		s_tvalid <= 1'b0;
		while (pending_out.size() != 0)
			@(posedge clk);
		repeat (LIST_DEPTH + 8) @(posedge clk);
		if (fails == 0)
			$display("tb passed");
		else
			$display("tb failed");
		$finish;
	end

	// Output side: random stall bursts, one long hold to back the block up.
	initial begin
		m_tready <= 1'b0;
		@(posedge arst_n);
		forever begin
			if (hold_output) begin
				hold_output = 1'b0;
				m_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end else if (!quiet_tail && $urandom_range(0, 7) == 0) begin
				m_tready <= 1'b0;
				repeat ($urandom_range(1, 9)) @(posedge clk);
			end
			m_tready <= 1'b1;
			@(posedge clk);
		end
	end

	// Compare each accepted word with the oldest pending result.
	always @(posedge clk) begin
		logic [7:0] want;
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_out.size() == 0) begin
				$display("%0t: unexpected word, expected none, actual %0d", $time, m_tdata);
				fails++;
			end else begin
				want = pending_out.pop_front();
				if (m_tdata !== want) begin
					$display("%0t: data_out mismatch, expected %0d, actual %0d",
						$time, want, m_tdata);
					fails++;
				end
			end
		end
	end

	// Hard stop in case the block hangs.
	initial begin
		#5_000_000;
		$display("tb failed");
		$finish;
	end

endmodule
